FILE: rtl/crc16_frame_append_and_check_macros.svh
// Assertion macros shared by the CRC-16 frame block's checker.
`ifndef CRC16_FRAME_APPEND_AND_CHECK_MACROS_SVH
`define CRC16_FRAME_APPEND_AND_CHECK_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CFAC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CFAC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/cfac_pkg.sv
// Types, constants and the CRC-16 byte update shared by the frame block.
`timescale 1ns / 1ps

package cfac_pkg;

   // Register indexes of the configuration port.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE           = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_COUNT = 1'd1;

   // CRC polynomial and frame limits.
   localparam logic [15:0] CRC_POLY  = 16'h8005;
   localparam logic [7:0]  MIN_COUNT = 8'd3;
   localparam logic [7:0]  CRC_BYTES = 8'd2;

   // Results one input byte can produce.
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned RESULT_CNT_WIDTH = 2;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_COUNT    = 2'd1,
      STATUS_LEN_MISMATCH = 2'd2,
      STATUS_CRC_MISMATCH = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_crc_byte;
      logic       frame_end;
      status_type status;
   } result_type;

   // Everything one byte hands to the result buffer.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0]  item;
      logic [RESULT_CNT_WIDTH-1:0]   count;
   } result_set_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] expected_count;
   } cfg_type;

   // Eight bit steps of the CRC, data LSB first against the register MSB.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (data[i] != c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/cfac_frame_ctrl.sv
// Frame tracking, CRC update and result generation for one byte per step.
`timescale 1ns / 1ps

module cfac_frame_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              frame_byte,
   input  cfac_pkg::cfg_type       cfg,
   output cfac_pkg::result_set_type results
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  bytes_seen_ff, bytes_seen_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic        length_wrong_ff, length_wrong_in;
   logic [7:0]  received_low_ff, received_low_in;

   logic        first;
   logic        bad_count;
   logic [7:0]  length;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic        len_wrong;
   logic        gen_last;
   logic        ver_data;
   logic        ver_low;
   logic        crc_match;
   cfac_pkg::status_type ver_status;

   // Values of the frame as seen by the current byte; a count byte restarts them.
   always_comb begin
      first     = (bytes_seen_ff == 8'd0);
      bad_count = first && (frame_byte < cfac_pkg::MIN_COUNT);
      length    = first ? frame_byte : frame_length_ff;
      crc_base  = first ? 16'd0 : crc_ff;
      len_wrong = first ? (!cfg.mode && (cfg.expected_count != 8'd0)
                           && (frame_byte != cfg.expected_count))
                        : length_wrong_ff;
      crc_next  = cfac_pkg::crc_feed(crc_base, frame_byte);
      gen_last  = (bytes_seen_ff >= 8'(length - cfac_pkg::MIN_COUNT));
      ver_data  = (bytes_seen_ff < 8'(length - cfac_pkg::CRC_BYTES));
      ver_low   = (bytes_seen_ff == 8'(length - cfac_pkg::CRC_BYTES));
      crc_match = (received_low_ff == crc_base[7:0]) && (frame_byte == crc_base[15:8]);
   end

   // Final status of a verified frame; a length error outranks a CRC error.
   always_comb begin
      priority if (len_wrong) begin
         ver_status = cfac_pkg::STATUS_LEN_MISMATCH;
      end else if (!crc_match) begin
         ver_status = cfac_pkg::STATUS_CRC_MISMATCH;
      end else begin
         ver_status = cfac_pkg::STATUS_OK;
      end
   end

   // Results for this byte.
   always_comb begin
      results = '0;
      results.item[0].out_byte = frame_byte;
      results.count = 2'd1;
      priority if (bad_count) begin
         results.item[0].frame_end = 1'b1;
         results.item[0].status    = cfac_pkg::STATUS_BAD_COUNT;
      end else if (cfg.mode) begin
         if (gen_last) begin
            results.item[1].out_byte    = crc_next[7:0];
            results.item[1].is_crc_byte = 1'b1;
            results.item[2].out_byte    = crc_next[15:8];
            results.item[2].is_crc_byte = 1'b1;
            results.item[2].frame_end   = 1'b1;
            results.count = 2'd3;
         end
      end else if (ver_data) begin
         results.item[0].is_crc_byte = 1'b0;
      end else if (ver_low) begin
         results.item[0].is_crc_byte = 1'b1;
      end else begin
         results.item[0].is_crc_byte = 1'b1;
         results.item[0].frame_end   = 1'b1;
         results.item[0].status      = ver_status;
      end
   end

   // Next frame state; any frame end clears it.
   always_comb begin
      crc_in          = crc_ff;
      bytes_seen_in   = bytes_seen_ff;
      frame_length_in = frame_length_ff;
      length_wrong_in = length_wrong_ff;
      received_low_in = received_low_ff;
      if (step) begin
         crc_in          = 16'd0;
         bytes_seen_in   = 8'd0;
         frame_length_in = 8'd0;
         length_wrong_in = 1'b0;
         received_low_in = 8'd0;
         priority if (bad_count || (cfg.mode && gen_last)) begin
            crc_in = 16'd0;
         end else if (cfg.mode || ver_data || ver_low) begin
            crc_in          = (cfg.mode || ver_data) ? crc_next : crc_base;
            bytes_seen_in   = 8'(bytes_seen_ff + 8'd1);
            frame_length_in = length;
            length_wrong_in = len_wrong;
            received_low_in = ver_low ? frame_byte : received_low_ff;
         end else begin
            crc_in = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff          <= 16'd0;
         bytes_seen_ff   <= 8'd0;
         frame_length_ff <= 8'd0;
         length_wrong_ff <= 1'b0;
         received_low_ff <= 8'd0;
      end else begin
         crc_ff          <= crc_in;
         bytes_seen_ff   <= bytes_seen_in;
         frame_length_ff <= frame_length_in;
         length_wrong_ff <= length_wrong_in;
         received_low_ff <= received_low_in;
      end
   end

endmodule

FILE: rtl/cfac_rsp_buf.sv
// Result buffer that holds up to three results of one byte and sends them in order.
`timescale 1ns / 1ps

module cfac_rsp_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  cfac_pkg::result_set_type results,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cfac_pkg::result_type     rsp_item
);

   cfac_pkg::result_type [cfac_pkg::MAX_RESULTS-1:0] slot_ff, slot_in;
   logic [cfac_pkg::RESULT_CNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0] head_ff, head_in;
   logic       pop;

   // The buffer can take a new set when it is empty or empties in this cycle.
   always_comb begin
      rsp_valid = (count_ff != '0);
      pop       = rsp_valid && rsp_ready;
      free      = (count_ff == '0) || ((count_ff == 2'd1) && rsp_ready);
      rsp_item  = slot_ff[head_ff];
   end

   // Load a new result set or step to the next waiting result.
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      head_in  = head_ff;
      if (load) begin
         slot_in  = results.item;
         count_in = results.count;
         head_in  = 2'd0;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         head_in  = head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

endmodule

FILE: rtl/crc16_frame_append_and_check.sv
// Top level of the CRC-16 frame generator and checker.
// A byte's first result is sent from the result buffer, after the input register.
// Throughput: one byte per cycle while results are taken; a byte that appends the CRC puts
// three results in the result buffer, which sends one each cycle that rsp_ready is high.
// Reset clears the frame state, the registers, the input stage and the result buffer.
`timescale 1ns / 1ps

module crc16_frame_append_and_check (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [7:0]                             req_frame_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_is_crc_byte,
   output logic                                   rsp_frame_end,
   output logic [1:0]                             rsp_status,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cfac_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [7:0]                             csr_wdata
);

   cfac_pkg::cfg_type        cfg_ff, cfg_in;
   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff, in_byte_in;
   logic                     step;
   logic                     buf_free;
   cfac_pkg::result_set_type results;
   cfac_pkg::result_type     rsp_item;

   // Configuration writes are always taken.
   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cfac_pkg::CSR_MODE:           cfg_in.mode           = csr_wdata[0];
            cfac_pkg::CSR_EXPECTED_COUNT: cfg_in.expected_count = csr_wdata;
            default:                      cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: a byte moves on when the result buffer can take its results.
   always_comb begin
      step        = in_valid_ff && buf_free;
      req_ready   = !in_valid_ff || buf_free;
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_frame_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   cfac_frame_ctrl u_frame_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .frame_byte (in_byte_ff),
      .cfg        (cfg_ff),
      .results    (results)
   );

   cfac_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .results   (results),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Result fields.
   assign rsp_out_byte    = rsp_item.out_byte;
   assign rsp_is_crc_byte = rsp_item.is_crc_byte;
   assign rsp_frame_end   = rsp_item.frame_end;
   assign rsp_status      = rsp_item.status;

endmodule

FILE: rtl/cfac_checker.sv
// Port-level assertions for the CRC-16 frame block, bound to its top level.
`timescale 1ns / 1ps
`include "crc16_frame_append_and_check_macros.svh"

module cfac_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_crc_byte,
   input logic       rsp_frame_end,
   input logic [1:0] rsp_status
);

   // A stalled result keeps its payload.
   `CFAC_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_crc_byte) && $stable(rsp_frame_end) && $stable(rsp_status)), "result changed while stalled")

   // Only the last result of a frame carries a nonzero status.
   `CFAC_ASSERT(a_status_at_end, (rsp_valid && !rsp_frame_end) |-> (rsp_status == cfac_pkg::STATUS_OK), "status set before frame end")

   // A frame that ends on a plain echo byte ended on a bad count.
   `CFAC_ASSERT(a_echo_end_bad_count, (rsp_valid && rsp_frame_end && !rsp_is_crc_byte) |-> (rsp_status == cfac_pkg::STATUS_BAD_COUNT), "frame ended on a data byte")

   // No result is offered right after reset.
   `CFAC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result offered after reset")

endmodule

bind crc16_frame_append_and_check cfac_checker u_cfac_checker (.*);
